// File: rtl/cstc_pkg.sv
// cstc_pkg: shared widths, constants, register indexes, op codes and types
// for the cascaded speed tilt controller; used by every rtl module, no dependencies
package cstc_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_SPEED_GAIN            = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_INTEGRAL_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WORKING_POINT_LEVEL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_GAIN            = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_DIFFERENCE_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_SPEED          = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RUN_MODE              = 3'd6;

   localparam int KP_W = 15;
   localparam int KI_W = 15;
   localparam int WP_W = 16;
   localparam int LG_W = 16;
   localparam int LD_W = 15;
   localparam int TS_W = 10;
   localparam int RM_W = 2;

   localparam logic [RM_W-1:0] RUN_MODE_RUN = 2'd1;

   localparam int SAMPLE_W = 16;
   localparam int ACC_W    = 12;
   localparam int SPEED_W  = 20;
   localparam int DEV_W    = 21;
   localparam int Q1_W     = 15;
   localparam int P_W      = 20;
   localparam int IQ_W     = 23;
   localparam int INT_W    = 32;
   localparam int ERR_W    = 24;
   localparam int MUL_A_W  = 24;
   localparam int MUL_B_W  = 17;
   localparam int PROD_W   = 40;
   localparam int ACCP_W   = 29;
   localparam int ACCD_W   = 36;
   localparam int SUM_W    = 37;

   localparam int DIV_W   = 40;
   localparam int DIGIT_W = 4;
   localparam int REM_W   = 10;
   localparam int MULT_W  = REM_W + DIGIT_W;
   localparam int DIGITS  = DIV_W / DIGIT_W;
   localparam int CNT_W   = $clog2(DIGITS);

   localparam int SPEED_SCALE  = 1000;
   localparam int DEV_SCALE    = 100;
   localparam int GAIN_SCALE   = 1000;
   localparam int DIFF_SCALE   = 5;
   localparam int ACC_MAX      = 2000;
   localparam int ENABLE_LIMIT = 100;
   localparam int SPEED_LIMIT  = 300000;

   localparam int DIV_SEL_W = 2;
   localparam logic [DIV_SEL_W-1:0] DIV_BY_5    = 2'd0;
   localparam logic [DIV_SEL_W-1:0] DIV_BY_100  = 2'd1;
   localparam logic [DIV_SEL_W-1:0] DIV_BY_1000 = 2'd2;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD        = 5'd1;
   localparam logic [OP_W-1:0] OP_DIV_DEV     = 5'd2;
   localparam logic [OP_W-1:0] OP_SAVE_Q1     = 5'd3;
   localparam logic [OP_W-1:0] OP_MUL_KP      = 5'd4;
   localparam logic [OP_W-1:0] OP_DIV_PROD    = 5'd5;
   localparam logic [OP_W-1:0] OP_SAVE_P      = 5'd6;
   localparam logic [OP_W-1:0] OP_MUL_KI      = 5'd7;
   localparam logic [OP_W-1:0] OP_SAVE_INT    = 5'd8;
   localparam logic [OP_W-1:0] OP_DIV_INT     = 5'd9;
   localparam logic [OP_W-1:0] OP_SAVE_TARGET = 5'd10;
   localparam logic [OP_W-1:0] OP_MUL_LG      = 5'd11;
   localparam logic [OP_W-1:0] OP_SAVE_ACCP   = 5'd12;
   localparam logic [OP_W-1:0] OP_MUL_LD      = 5'd13;
   localparam logic [OP_W-1:0] OP_SAVE_ACCD   = 5'd14;
   localparam logic [OP_W-1:0] OP_ACC         = 5'd15;
   localparam logic [OP_W-1:0] OP_FINISH      = 5'd16;

   typedef struct packed {
      logic [KP_W-1:0]        speed_gain;
      logic [KI_W-1:0]        speed_integral_gain;
      logic signed [WP_W-1:0] working_point_level;
      logic [LG_W-1:0]        level_gain;
      logic [LD_W-1:0]        level_difference_gain;
      logic signed [TS_W-1:0] target_speed;
      logic [RM_W-1:0]        run_mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      speed_gain:            15'd200,
      speed_integral_gain:   15'd150,
      working_point_level:   16'sd3181,
      level_gain:            16'd6400,
      level_difference_gain: 15'd200,
      target_speed:          10'sd10,
      run_mode:              RUN_MODE_RUN
   };

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [DIV_SEL_W-1:0] div_sel;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   // j times the selected divisor, j is a loop constant at every call site
   function automatic logic [MULT_W-1:0] div_multiple(input logic [DIV_SEL_W-1:0] sel,
                                                      input int j);
      logic [MULT_W-1:0] result;
      case (sel)
         DIV_BY_5:    result = MULT_W'(j * DIFF_SCALE);
         DIV_BY_100:  result = MULT_W'(j * DEV_SCALE);
         DIV_BY_1000: result = MULT_W'(j * GAIN_SCALE);
         default:     result = MULT_W'(j * GAIN_SCALE);
      endcase
      return result;
   endfunction

endpackage

// File: rtl/cstc_csr.sv
// cstc_csr: configuration register bank written through the csr channel
// depends on cstc_pkg
module cstc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cstc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cstc_pkg::CSR_DATA_W-1:0]    csr_data,
   output cstc_pkg::cfg_type                  cfg
);

   localparam int KP_W = cstc_pkg::KP_W;
   localparam int KI_W = cstc_pkg::KI_W;
   localparam int WP_W = cstc_pkg::WP_W;
   localparam int LG_W = cstc_pkg::LG_W;
   localparam int LD_W = cstc_pkg::LD_W;
   localparam int TS_W = cstc_pkg::TS_W;
   localparam int RM_W = cstc_pkg::RM_W;

   cstc_pkg::cfg_type cfg_ff;
   cstc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            cstc_pkg::REG_SPEED_GAIN:            cfg_in.speed_gain = csr_data[KP_W-1:0];
            cstc_pkg::REG_SPEED_INTEGRAL_GAIN:   cfg_in.speed_integral_gain = csr_data[KI_W-1:0];
            cstc_pkg::REG_WORKING_POINT_LEVEL:
               cfg_in.working_point_level = $signed(csr_data[WP_W-1:0]);
            cstc_pkg::REG_LEVEL_GAIN:            cfg_in.level_gain = csr_data[LG_W-1:0];
            cstc_pkg::REG_LEVEL_DIFFERENCE_GAIN:
               cfg_in.level_difference_gain = csr_data[LD_W-1:0];
            cstc_pkg::REG_TARGET_SPEED:          cfg_in.target_speed = $signed(csr_data[TS_W-1:0]);
            cstc_pkg::REG_RUN_MODE:              cfg_in.run_mode = csr_data[RM_W-1:0];
            default:                             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cstc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/cstc_cdiv.sv
// cstc_cdiv: radix-16 digit-serial divider of an unsigned value by 5, 100 or 1000
// one quotient digit per cycle; depends on cstc_pkg
module cstc_cdiv (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [cstc_pkg::DIV_SEL_W-1:0]      sel,
   input  logic [cstc_pkg::DIV_W-1:0]          dividend,
   output logic                                done,
   output logic [cstc_pkg::DIV_W-1:0]          quotient
);

   localparam int DIV_W   = cstc_pkg::DIV_W;
   localparam int DIGIT_W = cstc_pkg::DIGIT_W;
   localparam int REM_W   = cstc_pkg::REM_W;
   localparam int MULT_W  = cstc_pkg::MULT_W;
   localparam int DIGITS  = cstc_pkg::DIGITS;
   localparam int CNT_W   = cstc_pkg::CNT_W;

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic [DIV_W-1:0]                    num_ff, num_in;
   logic [DIV_W-1:0]                    quo_ff, quo_in;
   logic [REM_W-1:0]                    rem_ff, rem_in;
   logic [cstc_pkg::DIV_SEL_W-1:0]      sel_ff, sel_in;

   logic [MULT_W-1:0]  numer;
   logic [MULT_W-1:0]  sub;
   logic [DIGIT_W-1:0] digit;
   logic [REM_W-1:0]   rem_next;
   logic               last;

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign last     = (cnt_ff == CNT_W'(DIGITS - 1));

   // pick the largest multiple of the divisor that fits the partial remainder
   always_comb begin
      numer = {rem_ff, num_ff[DIV_W-1 -: DIGIT_W]};
      digit = '0;
      sub   = '0;
      for (int j = 1; j < 2 ** DIGIT_W; j++) begin
         if (numer >= cstc_pkg::div_multiple(sel_ff, j)) begin
            digit = DIGIT_W'(j);
            sub   = cstc_pkg::div_multiple(sel_ff, j);
         end
      end
      rem_next = REM_W'(numer - sub);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      sel_in  = sel_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         sel_in  = sel;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         quo_in = {quo_ff[DIV_W-DIGIT_W-1:0], digit};
         rem_in = rem_next;
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      sel_ff <= sel_in;
   end

endmodule

// File: rtl/cstc_dp.sv
// cstc_dp: datapath with loop state, error history, shared multiplier and result registers
// depends on cstc_pkg and cstc_cdiv
module cstc_dp #(
   parameter int HISTORY_DEPTH = cstc_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  cstc_pkg::cmd_type                        cmd,
   output cstc_pkg::status_type                     status,
   input  cstc_pkg::cfg_type                        cfg,
   input  logic signed [cstc_pkg::SAMPLE_W-1:0]     req_sensor_sample,
   output logic signed [cstc_pkg::ACC_W-1:0]        rsp_acceleration,
   output logic signed [cstc_pkg::SPEED_W-1:0]      rsp_drive_speed,
   output logic                                     rsp_output_disabled
);

   localparam int SAMPLE_W = cstc_pkg::SAMPLE_W;
   localparam int ACC_W    = cstc_pkg::ACC_W;
   localparam int SPEED_W  = cstc_pkg::SPEED_W;
   localparam int DEV_W    = cstc_pkg::DEV_W;
   localparam int Q1_W     = cstc_pkg::Q1_W;
   localparam int P_W      = cstc_pkg::P_W;
   localparam int IQ_W     = cstc_pkg::IQ_W;
   localparam int INT_W    = cstc_pkg::INT_W;
   localparam int ERR_W    = cstc_pkg::ERR_W;
   localparam int MUL_A_W  = cstc_pkg::MUL_A_W;
   localparam int MUL_B_W  = cstc_pkg::MUL_B_W;
   localparam int PROD_W   = cstc_pkg::PROD_W;
   localparam int ACCP_W   = cstc_pkg::ACCP_W;
   localparam int ACCD_W   = cstc_pkg::ACCD_W;
   localparam int SUM_W    = cstc_pkg::SUM_W;
   localparam int DIV_W    = cstc_pkg::DIV_W;

   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [DEV_W-1:0]    dev_ff, dev_in;
   logic signed [Q1_W-1:0]     q1_ff, q1_in;
   logic signed [P_W-1:0]      p_ff, p_in;
   logic signed [INT_W-1:0]    integral_ff, integral_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [ERR_W-1:0]    hist_ff [HISTORY_DEPTH];
   logic signed [ERR_W-1:0]    hist_in [HISTORY_DEPTH];
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       neg_ff, neg_in;
   logic signed [ACCP_W-1:0]   accp_ff, accp_in;
   logic signed [ACCD_W-1:0]   accd_ff, accd_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       en_ff, en_in;
   logic signed [SPEED_W-1:0]  speed_ff, speed_in;
   logic                       dis_ff, dis_in;
   logic signed [ACC_W-1:0]    out_acc_ff, out_acc_in;
   logic signed [SPEED_W-1:0]  out_speed_ff, out_speed_in;
   logic                       out_dis_ff, out_dis_in;

   logic                       div_start;
   logic                       div_done;
   logic [DIV_W-1:0]           div_quo;
   logic signed [DIV_W-1:0]    div_src;
   logic signed [DIV_W-1:0]    div_mag;
   logic signed [DIV_W-1:0]    sq;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_A_W+MUL_B_W-1:0] product;
   logic signed [SPEED_W-1:0]  speed_eff;
   logic signed [ERR_W-1:0]    target;
   logic signed [SUM_W-1:0]    sum;
   logic signed [SPEED_W-1:0]  speed_new;
   logic                       run;

   cstc_cdiv u_cdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sel      (cmd.div_sel),
      .dividend (div_mag),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign status.div_done     = div_done;
   assign rsp_acceleration    = out_acc_ff;
   assign rsp_drive_speed     = out_speed_ff;
   assign rsp_output_disabled = out_dis_ff;
   assign run                 = (cfg.run_mode == cstc_pkg::RUN_MODE_RUN);

   // divider operand, sign kept aside so the quotient truncates toward zero
   always_comb begin
      case (cmd.op)
         cstc_pkg::OP_DIV_DEV:  div_src = DIV_W'(dev_ff);
         cstc_pkg::OP_DIV_INT:  div_src = DIV_W'(integral_ff);
         cstc_pkg::OP_DIV_PROD: div_src = DIV_W'(prod_ff);
         default:               div_src = DIV_W'(prod_ff);
      endcase
      div_start = (cmd.op == cstc_pkg::OP_DIV_DEV) || (cmd.op == cstc_pkg::OP_DIV_INT) ||
                  (cmd.op == cstc_pkg::OP_DIV_PROD);
      div_mag   = div_src[DIV_W-1] ? -div_src : div_src;
      sq        = neg_ff ? -$signed(div_quo) : $signed(div_quo);
   end

   always_comb begin
      case (cmd.op)
         cstc_pkg::OP_MUL_KP: begin
            mul_a = MUL_A_W'(q1_ff);
            mul_b = $signed(MUL_B_W'(cfg.speed_gain));
         end
         cstc_pkg::OP_MUL_KI: begin
            mul_a = MUL_A_W'(q1_ff);
            mul_b = $signed(MUL_B_W'(cfg.speed_integral_gain));
         end
         cstc_pkg::OP_MUL_LG: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed(MUL_B_W'(cfg.level_gain));
         end
         cstc_pkg::OP_MUL_LD: begin
            mul_a = MUL_A_W'(err_ff - hist_ff[HISTORY_DEPTH-1]);
            mul_b = $signed(MUL_B_W'(cfg.level_difference_gain));
         end
         default: begin
            mul_a = MUL_A_W'(q1_ff);
            mul_b = $signed(MUL_B_W'(cfg.speed_gain));
         end
      endcase
      product = mul_a * mul_b;
   end

   always_comb begin
      speed_eff = dis_ff ? '0 : speed_ff;
      target    = ERR_W'($signed(cfg.working_point_level)) + ERR_W'(p_ff)
                + ERR_W'($signed(sq[IQ_W-1:0]));
      sum       = SUM_W'(accp_ff) + SUM_W'(accd_ff);
      speed_new = en_ff ? speed_ff + SPEED_W'(acc_ff) : speed_ff;
   end

   always_comb begin
      sample_in    = sample_ff;
      dev_in       = dev_ff;
      q1_in        = q1_ff;
      p_in         = p_ff;
      integral_in  = integral_ff;
      err_in       = err_ff;
      hist_in      = hist_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      accp_in      = accp_ff;
      accd_in      = accd_ff;
      acc_in       = acc_ff;
      en_in        = en_ff;
      speed_in     = speed_ff;
      dis_in       = dis_ff;
      out_acc_in   = out_acc_ff;
      out_speed_in = out_speed_ff;
      out_dis_in   = out_dis_ff;
      if (div_start) begin
         neg_in = div_src[DIV_W-1];
      end
      case (cmd.op)
         cstc_pkg::OP_LOAD: begin
            sample_in = req_sensor_sample;
            speed_in  = speed_eff;
            if (dis_ff) begin
               integral_in = '0;
            end
            dev_in = DEV_W'($signed(cfg.target_speed)) * DEV_W'(cstc_pkg::SPEED_SCALE)
                   - DEV_W'(speed_eff);
         end
         cstc_pkg::OP_SAVE_Q1: q1_in = $signed(sq[Q1_W-1:0]);
         cstc_pkg::OP_SAVE_P:  p_in = -$signed(sq[P_W-1:0]);
         cstc_pkg::OP_SAVE_INT: integral_in = integral_ff - $signed(sq[INT_W-1:0]);
         cstc_pkg::OP_SAVE_TARGET: begin
            hist_in[0] = err_ff;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
               hist_in[i] = hist_ff[i-1];
            end
            err_in = target - ERR_W'(sample_ff);
         end
         cstc_pkg::OP_MUL_KP, cstc_pkg::OP_MUL_KI, cstc_pkg::OP_MUL_LG,
         cstc_pkg::OP_MUL_LD: prod_in = PROD_W'(product);
         cstc_pkg::OP_SAVE_ACCP: accp_in = $signed(sq[ACCP_W-1:0]);
         cstc_pkg::OP_SAVE_ACCD: accd_in = $signed(sq[ACCD_W-1:0]);
         cstc_pkg::OP_ACC: begin
            if (sum > cstc_pkg::ACC_MAX) begin
               acc_in = ACC_W'(cstc_pkg::ACC_MAX);
            end else if (sum < -cstc_pkg::ACC_MAX) begin
               acc_in = ACC_W'(-cstc_pkg::ACC_MAX);
            end else begin
               acc_in = ACC_W'(sum);
            end
            en_in = !dis_ff || (accp_ff < cstc_pkg::ENABLE_LIMIT &&
                                accp_ff > -cstc_pkg::ENABLE_LIMIT && run);
         end
         cstc_pkg::OP_FINISH: begin
            speed_in     = speed_new;
            dis_in       = !en_ff || !run || speed_new > cstc_pkg::SPEED_LIMIT ||
                           speed_new < -cstc_pkg::SPEED_LIMIT;
            out_acc_in   = acc_ff;
            out_speed_in = speed_new;
            out_dis_in   = dis_in;
         end
         default: begin
            sample_in = sample_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff    <= '0;
         integral_ff <= '0;
         dis_ff      <= 1'b1;
         err_ff      <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         speed_ff    <= speed_in;
         integral_ff <= integral_in;
         dis_ff      <= dis_in;
         err_ff      <= err_in;
         hist_ff     <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      dev_ff       <= dev_in;
      q1_ff        <= q1_in;
      p_ff         <= p_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      accp_ff      <= accp_in;
      accd_ff      <= accd_in;
      acc_ff       <= acc_in;
      en_ff        <= en_in;
      out_acc_ff   <= out_acc_in;
      out_speed_ff <= out_speed_in;
      out_dis_ff   <= out_dis_in;
   end

endmodule

// File: rtl/cstc_ctrl.sv
// cstc_ctrl: sequencer that steps the datapath through one control tick
// and owns the request and response handshakes; depends on cstc_pkg
module cstc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  cstc_pkg::status_type  status,
   output cstc_pkg::cmd_type     cmd
);

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_IDLE     = 5'd0;
   localparam logic [ST_W-1:0] ST_DEV_DIV  = 5'd1;
   localparam logic [ST_W-1:0] ST_DEV_WAIT = 5'd2;
   localparam logic [ST_W-1:0] ST_MUL_KP   = 5'd3;
   localparam logic [ST_W-1:0] ST_KP_DIV   = 5'd4;
   localparam logic [ST_W-1:0] ST_KP_WAIT  = 5'd5;
   localparam logic [ST_W-1:0] ST_MUL_KI   = 5'd6;
   localparam logic [ST_W-1:0] ST_KI_DIV   = 5'd7;
   localparam logic [ST_W-1:0] ST_KI_WAIT  = 5'd8;
   localparam logic [ST_W-1:0] ST_INT_DIV  = 5'd9;
   localparam logic [ST_W-1:0] ST_INT_WAIT = 5'd10;
   localparam logic [ST_W-1:0] ST_MUL_LG   = 5'd11;
   localparam logic [ST_W-1:0] ST_LG_DIV   = 5'd12;
   localparam logic [ST_W-1:0] ST_LG_WAIT  = 5'd13;
   localparam logic [ST_W-1:0] ST_MUL_LD   = 5'd14;
   localparam logic [ST_W-1:0] ST_LD_DIV   = 5'd15;
   localparam logic [ST_W-1:0] ST_LD_WAIT  = 5'd16;
   localparam logic [ST_W-1:0] ST_ACC      = 5'd17;
   localparam logic [ST_W-1:0] ST_FINISH   = 5'd18;

   logic [ST_W-1:0] state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            finish;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.op      = cstc_pkg::OP_NONE;
      cmd.div_sel = cstc_pkg::DIV_BY_1000;
      finish      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = cstc_pkg::OP_LOAD;
               state_in = ST_DEV_DIV;
            end
         end
         ST_DEV_DIV: begin
            cmd.op      = cstc_pkg::OP_DIV_DEV;
            cmd.div_sel = cstc_pkg::DIV_BY_100;
            state_in    = ST_DEV_WAIT;
         end
         ST_DEV_WAIT: begin
            if (status.div_done) begin
               cmd.op   = cstc_pkg::OP_SAVE_Q1;
               state_in = ST_MUL_KP;
            end
         end
         ST_MUL_KP: begin
            cmd.op   = cstc_pkg::OP_MUL_KP;
            state_in = ST_KP_DIV;
         end
         ST_KP_DIV: begin
            cmd.op   = cstc_pkg::OP_DIV_PROD;
            state_in = ST_KP_WAIT;
         end
         ST_KP_WAIT: begin
            if (status.div_done) begin
               cmd.op   = cstc_pkg::OP_SAVE_P;
               state_in = ST_MUL_KI;
            end
         end
         ST_MUL_KI: begin
            cmd.op   = cstc_pkg::OP_MUL_KI;
            state_in = ST_KI_DIV;
         end
         ST_KI_DIV: begin
            cmd.op   = cstc_pkg::OP_DIV_PROD;
            state_in = ST_KI_WAIT;
         end
         ST_KI_WAIT: begin
            if (status.div_done) begin
               cmd.op   = cstc_pkg::OP_SAVE_INT;
               state_in = ST_INT_DIV;
            end
         end
         ST_INT_DIV: begin
            cmd.op   = cstc_pkg::OP_DIV_INT;
            state_in = ST_INT_WAIT;
         end
         ST_INT_WAIT: begin
            if (status.div_done) begin
               cmd.op   = cstc_pkg::OP_SAVE_TARGET;
               state_in = ST_MUL_LG;
            end
         end
         ST_MUL_LG: begin
            cmd.op   = cstc_pkg::OP_MUL_LG;
            state_in = ST_LG_DIV;
         end
         ST_LG_DIV: begin
            cmd.op   = cstc_pkg::OP_DIV_PROD;
            state_in = ST_LG_WAIT;
         end
         ST_LG_WAIT: begin
            if (status.div_done) begin
               cmd.op   = cstc_pkg::OP_SAVE_ACCP;
               state_in = ST_MUL_LD;
            end
         end
         ST_MUL_LD: begin
            cmd.op   = cstc_pkg::OP_MUL_LD;
            state_in = ST_LD_DIV;
         end
         ST_LD_DIV: begin
            cmd.op      = cstc_pkg::OP_DIV_PROD;
            cmd.div_sel = cstc_pkg::DIV_BY_5;
            state_in    = ST_LD_WAIT;
         end
         ST_LD_WAIT: begin
            if (status.div_done) begin
               cmd.op   = cstc_pkg::OP_SAVE_ACCD;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.op   = cstc_pkg::OP_ACC;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op   = cstc_pkg::OP_FINISH;
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/cascaded_speed_tilt_controller.sv
// cascaded_speed_tilt_controller: top level, config bank, sequencer and datapath
// depends on cstc_pkg, cstc_csr, cstc_ctrl, cstc_dp (and cstc_cdiv below it)
//
//   channel | ports                         | handshake
//   --------+-------------------------------+---------------------------
//   req     | req_sensor_sample             | req_valid / req_stall
//   rsp     | rsp_acceleration,             | rsp_valid / rsp_stall
//           | rsp_drive_speed,              |
//           | rsp_output_disabled           |
//   csr     | csr_index, csr_data           | csr_valid / csr_ready
//
// one transaction runs from accept to result through six divisions on the one
// shared radix-16 divider, each producing ten quotient digits, plus the multiplier
// and update steps.
// a new sample is taken the cycle after the previous result is loaded.
// synchronous active-high reset; csr_ready is always high.
// a stalled result holds in the output register; the next tick runs up to its last step.
module cascaded_speed_tilt_controller #(
   parameter int HISTORY_DEPTH = cstc_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [cstc_pkg::SAMPLE_W-1:0]     req_sensor_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [cstc_pkg::ACC_W-1:0]        rsp_acceleration,
   output logic signed [cstc_pkg::SPEED_W-1:0]      rsp_drive_speed,
   output logic                                     rsp_output_disabled,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [cstc_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [cstc_pkg::CSR_DATA_W-1:0]          csr_data
);

   cstc_pkg::cfg_type    cfg;
   cstc_pkg::cmd_type    cmd;
   cstc_pkg::status_type status;

   cstc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cstc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cstc_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .cfg                 (cfg),
      .req_sensor_sample   (req_sensor_sample),
      .rsp_acceleration    (rsp_acceleration),
      .rsp_drive_speed     (rsp_drive_speed),
      .rsp_output_disabled (rsp_output_disabled)
   );

endmodule
